FILE: design/zero_sum_subarray_finder_assert.svh
// Assertion macros for the zero-sum subarray finder; empty when SYNTH is defined.
`ifndef ZERO_SUM_SUBARRAY_FINDER_ASSERT_SVH
`define ZERO_SUM_SUBARRAY_FINDER_ASSERT_SVH

`ifndef SYNTH
`define ZSSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ZSSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ZSSF_ASSERT_IMP(lbl, ante, cons)
`define ZSSF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: design/zssf_pkg.sv
// Shared types and constants of the zero-sum subarray finder.
package zssf_pkg;

  localparam int OUT_IDX_W = 6;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] start_index;
    logic [OUT_IDX_W-1:0] end_index;
    logic                 last_of_run;
    logic                 full_res;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

FILE: design/zssf_if.sv
// Valid/ready channel interfaces for element items and result items.
interface zssf_in_if #(
  parameter int ELEMENT_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic                            first_of_array;
  logic signed [ELEMENT_WIDTH-1:0] element;

  modport source (output valid, output first_of_array, output element, input ready);
  modport sink   (input valid, input first_of_array, input element, output ready);
endinterface

interface zssf_out_if;
  logic                           valid;
  logic                           ready;
  logic [zssf_pkg::OUT_IDX_W-1:0] start_index;
  logic [zssf_pkg::OUT_IDX_W-1:0] end_index;
  logic                           last_of_run;
  logic                           full_res;

  modport source (output valid, output start_index, output end_index,
                  output last_of_run, output full_res, input ready);
  modport sink   (input valid, input start_index, input end_index,
                  input last_of_run, input full_res, output ready);
endinterface

FILE: design/zssf_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
module zssf_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/zssf_outreg.sv
// Result output register: holds one result item until the sink takes it.
module zssf_outreg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  zssf_pkg::res_t res,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_ready,
  output zssf_pkg::res_t out_res
);

  logic           out_valid_r;
  logic           out_valid_nxt;
  zssf_pkg::res_t out_res_r;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: design/zssf_ctrl.sv
// Sequencer: prefix sum, store update, prefix scan at one compare per unstalled cycle.
module zssf_ctrl #(
  parameter int MAX_ELEMENTS  = 64,
  parameter int ELEMENT_WIDTH = 16,
  parameter int SUM_W         = ELEMENT_WIDTH + $clog2(MAX_ELEMENTS),
  parameter int AW            = $clog2(MAX_ELEMENTS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_first,
  input  logic signed [ELEMENT_WIDTH-1:0] in_elem,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [SUM_W-1:0]                wr_data,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr,
  input  logic [SUM_W-1:0]                rd_data,
  output logic                            push,
  output zssf_pkg::res_t                  res,
  input  logic                            out_free
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  zssf_pkg::state_t   state_r, state_nxt;
  logic signed [SUM_W-1:0] running_r, running_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               data_v_r, data_v_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [AW-1:0]      pend_start_r, pend_start_nxt;
  logic               pend_full_r, pend_full_nxt;

  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum_add;
  logic [AW-1:0]      pos_in;
  logic               match;
  logic               stall;

  assign base    = in_first ? '0 : running_r;
  assign sum_add = base + SUM_W'(in_elem);
  assign pos_in  = in_first ? '0 : count_r[AW-1:0];
  assign match   = data_v_r && (rd_data == sum_r);
  // a new match needs the pending result to leave first
  assign stall   = match && pend_v_r && !out_free;

  assign rd_addr = addr_r;
  assign wr_addr = pos_in;
  assign wr_data = sum_add;

  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    pos_nxt        = pos_r;
    addr_nxt       = addr_r;
    cmp_idx_nxt    = cmp_idx_r;
    data_v_nxt     = data_v_r;
    pend_v_nxt     = pend_v_r;
    pend_start_nxt = pend_start_r;
    pend_full_nxt  = pend_full_r;
    in_ready       = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    push           = 1'b0;
    res            = '0;
    case (state_r)
      zssf_pkg::ST_IDLE: begin
        // no item is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          if (!in_first && count_r == CNT_W'(MAX_ELEMENTS)) begin
            pend_v_nxt     = 1'b1;
            pend_full_nxt  = 1'b1;
            pend_start_nxt = '0;
            pos_nxt        = '0;
            state_nxt      = zssf_pkg::ST_DONE;
          end else begin
            wr_en          = 1'b1;
            running_nxt    = sum_add;
            count_nxt      = in_first ? CNT_W'(1) : CNT_W'(count_r + 1'b1);
            sum_nxt        = sum_add;
            pos_nxt        = pos_in;
            pend_v_nxt     = (sum_add == '0);
            pend_start_nxt = '0;
            pend_full_nxt  = 1'b0;
            addr_nxt       = '0;
            data_v_nxt     = 1'b0;
            state_nxt      = zssf_pkg::ST_SCAN;
          end
        end
      end
      zssf_pkg::ST_SCAN: begin
        if (!stall) begin
          if (match) begin
            if (pend_v_r) begin
              push              = 1'b1;
              res.start_index   = zssf_pkg::OUT_IDX_W'(pend_start_r);
              res.end_index     = zssf_pkg::OUT_IDX_W'(pos_r);
            end
            pend_v_nxt     = 1'b1;
            pend_start_nxt = AW'(cmp_idx_r + 1'b1);
          end
          rd_en      = (addr_r != pos_r);
          data_v_nxt = rd_en;
          if (rd_en) begin
            addr_nxt    = AW'(addr_r + 1'b1);
            cmp_idx_nxt = addr_r;
          end else begin
            state_nxt = zssf_pkg::ST_DONE;
          end
        end
      end
      zssf_pkg::ST_DONE: begin
        if (!pend_v_r) begin
          state_nxt = zssf_pkg::ST_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          res.start_index = zssf_pkg::OUT_IDX_W'(pend_start_r);
          res.end_index   = zssf_pkg::OUT_IDX_W'(pos_r);
          res.last_of_run = 1'b1;
          res.full_res    = pend_full_r;
          pend_v_nxt      = 1'b0;
          state_nxt       = zssf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = zssf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= zssf_pkg::ST_IDLE;
      running_r <= '0;
      count_r   <= '0;
      data_v_r  <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      running_r <= running_nxt;
      count_r   <= count_nxt;
      data_v_r  <= data_v_nxt;
      pend_v_r  <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r        <= sum_nxt;
    pos_r        <= pos_nxt;
    addr_r       <= addr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    pend_start_r <= pend_start_nxt;
    pend_full_r  <= pend_full_nxt;
  end

`include "zero_sum_subarray_finder_assert.svh"

  `ZSSF_ASSERT_IMP(a_push_when_free, push, out_free)
  `ZSSF_ASSERT_IMP(a_scan_addr_bound, state_r == zssf_pkg::ST_SCAN, addr_r <= pos_r)
  `ZSSF_ASSERT_NXT(a_last_ends_item, push && res.last_of_run, state_r == zssf_pkg::ST_IDLE)
  `ZSSF_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_ELEMENTS))

endmodule

FILE: design/zero_sum_subarray_finder.sv
// Zero-sum subarray finder: element items in, (start, end) index result items out.
// Each accepted element is added to a running prefix sum that is written to a prefix
// RAM at the element's position; the stored prefixes of the earlier positions are then
// read back one per cycle through the RAM's single read port, unless a stalled result
// holds the scan, and compared against the new sum; each match gives a result item. An
// element at position i occupies the block from its acceptance through the scan and a
// closing step, and longer while the result sink stalls; the input is not ready
// meanwhile. A zero prefix gives (0, i) first, the last item of an element carries
// last_of_run, and an element past capacity gives a single full_res item.
module zero_sum_subarray_finder #(
  parameter int MAX_ELEMENTS  = 64,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  zssf_in_if.sink        in_ch,
  zssf_out_if.source     out_ch
);

  localparam int SUM_W = ELEMENT_WIDTH + $clog2(MAX_ELEMENTS);
  localparam int AW    = $clog2(MAX_ELEMENTS);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [SUM_W-1:0]  wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [SUM_W-1:0]  rd_data;
  logic              push;
  logic              out_free;
  zssf_pkg::res_t    res;
  zssf_pkg::res_t    out_res;

  zssf_ctrl #(
    .MAX_ELEMENTS  (MAX_ELEMENTS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .SUM_W         (SUM_W),
    .AW            (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_first (in_ch.first_of_array),
    .in_elem  (in_ch.element),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .push     (push),
    .res      (res),
    .out_free (out_free)
  );

  zssf_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_prefix_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  zssf_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.start_index = out_res.start_index;
  assign out_ch.end_index   = out_res.end_index;
  assign out_ch.last_of_run = out_res.last_of_run;
  assign out_ch.full_res    = out_res.full_res;

endmodule
